>>> hw/rtl/srsm_pkg.sv
// ----------------------------------------------------------------------------
// Sample rate skew monitor package
// Shared widths, register codes and reset values.
// ----------------------------------------------------------------------------
package srsm_pkg;

  localparam int unsigned COUNT_BITS_DEF = 48;
  localparam int unsigned RATIO_FRAC_DEF = 16;
  localparam int unsigned RATE_FRAC      = 16;
  localparam int unsigned RATE_W         = 32;
  localparam int unsigned RATIO_W        = 32;
  localparam int unsigned CFG_W          = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned TOL_W          = 16;
  localparam int unsigned RUN_W          = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_MAX_GAP       = 2'd1,
    CFG_TOLERANCE     = 2'd2,
    CFG_BAD_NEEDED    = 2'd3
  } cfg_index_t;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 32'd1000000;
  localparam logic [CFG_W-1:0] MAX_GAP_RST       = 32'd200000;
  localparam logic [TOL_W-1:0] TOLERANCE_RST     = 16'd655;
  localparam logic [RUN_W-1:0] BAD_NEEDED_RST    = 16'd3;

endpackage

>>> hw/rtl/srsm_ratio_unit.sv
// ----------------------------------------------------------------------------
// Sample rate skew monitor ratio unit
// Forms rate*span with a shared 32x32 multiplier, then divides the delivered
// frame count by it one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module srsm_ratio_unit #(
  parameter int unsigned COUNT_BITS      = srsm_pkg::COUNT_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = srsm_pkg::RATIO_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COUNT_BITS-1:0]         delivered,
  input  logic [COUNT_BITS-1:0]         span,
  input  logic [srsm_pkg::RATE_W-1:0]   rate,
  output logic                          done,
  output logic [srsm_pkg::RATIO_W-1:0]  ratio
);
  import srsm_pkg::*;

  localparam int unsigned NCH      = (COUNT_BITS + 31) / 32;
  localparam int unsigned CH_W     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned SPAN_PAD = NCH * 32;
  localparam int unsigned DEN_W    = COUNT_BITS + RATE_W;
  localparam int unsigned W        = DEN_W + RATIO_W;
  localparam int unsigned SH       = RATE_FRAC + RATIO_FRAC_BITS;
  localparam int unsigned STEPS    = RATIO_W + 1;
  localparam int unsigned STEP_W   = $clog2(STEPS);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_ACC  = 4'b0100,
    U_DIV  = 4'b1000
  } ustate_t;

  ustate_t               state;
  logic [SPAN_PAD-1:0]   span_pad;
  logic [RATE_W-1:0]     rate_r;
  logic [CH_W-1:0]       chunk;
  logic [63:0]           prod;
  logic [W-1:0]          den_sh;
  logic [W-1:0]          rem;
  logic [RATIO_W:0]      quo;
  logic [RATIO_W:0]      quo_next;
  logic [STEP_W-1:0]     step;
  logic                  fits;

  assign fits     = rem >= den_sh;
  assign quo_next = {quo[RATIO_W-1:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == U_DIV) && (step == STEP_W'(STEPS - 1));
      unique case (state)
        U_IDLE: begin
          if (start) begin
            span_pad <= SPAN_PAD'(span);
            rate_r   <= rate;
            rem      <= W'(delivered) << SH;
            den_sh   <= '0;
            chunk    <= '0;
            state    <= U_MUL;
          end
        end
        U_MUL: begin
          prod  <= rate_r * span_pad[chunk*32 +: 32];
          state <= U_ACC;
        end
        U_ACC: begin
          den_sh <= den_sh + (W'(prod) << (RATIO_W + 32 * chunk));
          if (chunk == CH_W'(NCH - 1)) begin
            step  <= '0;
            quo   <= '0;
            state <= U_DIV;
          end else begin
            chunk <= chunk + 1'b1;
            state <= U_MUL;
          end
        end
        U_DIV: begin
          if (fits) begin
            rem <= rem - den_sh;
          end
          quo    <= quo_next;
          den_sh <= den_sh >> 1;
          step   <= step + 1'b1;
          if (step == STEP_W'(STEPS - 1)) begin
            ratio <= quo_next[RATIO_W] ? '1 : quo_next[RATIO_W-1:0];
            state <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/sample_rate_skew_monitor_top.sv
// ----------------------------------------------------------------------------
// Sample rate skew monitor
// Tracks frame delivery against the nominal rate over measuring windows and
// counts consecutive windows whose ratio is out of tolerance.
// ----------------------------------------------------------------------------
// An item that closes no window passes from the evaluate state to the output
// state. An item that closes a window also runs the ratio unit (a multiply
// and accumulate per 32-bit chunk of the span, then the divide) and the finish
// state, which collects the ratio and updates the run. One item at a time:
// the next item is taken the cycle after the result is written to the output
// register. Reset clears the control and window state and loads defaults.
// ----------------------------------------------------------------------------
module sample_rate_skew_monitor_top #(
  parameter int unsigned COUNT_BITS      = srsm_pkg::COUNT_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = srsm_pkg::RATIO_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [srsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srsm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [COUNT_BITS-1:0]          frame_count,
  input  logic [srsm_pkg::RATE_W-1:0]    nominal_rate,
  input  logic [COUNT_BITS-1:0]          time_now,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           window_closed,
  output logic [srsm_pkg::RATIO_W-1:0]   measured_ratio,
  output logic [srsm_pkg::RUN_W-1:0]     bad_count,
  output logic                           skewed
);
  import srsm_pkg::*;

  localparam int unsigned GAP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int unsigned DEV_W = RATIO_W + TOL_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_WAIT = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      window_length;
  logic [CFG_W-1:0]      max_gap;
  logic [TOL_W-1:0]      tolerance;
  logic [RUN_W-1:0]      bad_needed;

  logic [COUNT_BITS-1:0] in_frames;
  logic [RATE_W-1:0]     in_rate;
  logic [COUNT_BITS-1:0] in_now;

  logic                  seen_flag;
  logic [COUNT_BITS-1:0] win_frames;
  logic [COUNT_BITS-1:0] win_time;
  logic [COUNT_BITS-1:0] prev_frames;
  logic [COUNT_BITS-1:0] prev_time;
  logic [RATE_W-1:0]     held_rate;
  logic [RUN_W-1:0]      bad_run;
  logic [RATIO_W-1:0]    last_ratio;
  logic                  closed;

  logic [COUNT_BITS-1:0] gap;
  logic [COUNT_BITS-1:0] span;
  logic [COUNT_BITS-1:0] delivered;
  logic                  gap_big;
  logic                  disc;
  logic                  span_ok;
  logic                  ratio_start;
  logic                  ratio_done;
  logic [RATIO_W-1:0]    ratio;
  logic [RATIO_W-1:0]    one;
  logic [RATIO_W-1:0]    dev;
  logic                  out_of_tol;

  assign in_stall = state != S_IDLE;

  assign gap       = in_now - prev_time;
  assign span      = in_now - win_time;
  assign delivered = in_frames - win_frames;
  assign gap_big   = (in_now > prev_time) && (GAP_W'(gap) > GAP_W'(max_gap));
  assign disc      = !seen_flag || gap_big || (in_frames < prev_frames) ||
                     (in_rate != held_rate);
  assign span_ok   = (in_now >= win_time) && (GAP_W'(span) >= GAP_W'(window_length));
  assign ratio_start = (state == S_EVAL) && (in_rate != '0) && !disc && span_ok;

  assign one        = RATIO_W'(1) << RATIO_FRAC_BITS;
  assign dev        = (ratio < one) ? one - ratio : ratio - one;
  assign out_of_tol = {dev, {TOL_W{1'b0}}} > (DEV_W'(tolerance) << RATIO_FRAC_BITS);

  srsm_ratio_unit #(
    .COUNT_BITS      (COUNT_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_ratio (
    .clk       (clk),
    .rst       (rst),
    .start     (ratio_start),
    .delivered (delivered),
    .span      (span),
    .rate      (in_rate),
    .done      (ratio_done),
    .ratio     (ratio)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      max_gap       <= MAX_GAP_RST;
      tolerance     <= TOLERANCE_RST;
      bad_needed    <= BAD_NEEDED_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WINDOW_LENGTH: window_length <= cfg_data;
        CFG_MAX_GAP:       max_gap       <= cfg_data;
        CFG_TOLERANCE:     tolerance     <= cfg_data[TOL_W-1:0];
        CFG_BAD_NEEDED:    bad_needed    <= cfg_data[RUN_W-1:0];
        default:           max_gap       <= max_gap;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      seen_flag   <= 1'b0;
      win_frames  <= '0;
      win_time    <= '0;
      prev_frames <= '0;
      prev_time   <= '0;
      held_rate   <= '0;
      bad_run     <= '0;
      last_ratio  <= '0;
      closed      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_frames <= frame_count;
            in_rate   <= nominal_rate;
            in_now    <= time_now;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (in_rate == '0) begin
            seen_flag <= 1'b0;
            bad_run   <= '0;
            closed    <= 1'b0;
            state     <= S_OUT;
          end else if (disc) begin
            seen_flag   <= 1'b1;
            win_frames  <= in_frames;
            win_time    <= in_now;
            held_rate   <= in_rate;
            bad_run     <= '0;
            prev_frames <= in_frames;
            prev_time   <= in_now;
            closed      <= 1'b0;
            state       <= S_OUT;
          end else begin
            prev_frames <= in_frames;
            prev_time   <= in_now;
            if (span_ok) begin
              win_frames <= in_frames;
              win_time   <= in_now;
              closed     <= 1'b1;
              state      <= S_WAIT;
            end else begin
              closed <= 1'b0;
              state  <= S_OUT;
            end
          end
        end
        S_WAIT: begin
          if (ratio_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          last_ratio <= ratio;
          if (out_of_tol) begin
            if (bad_run != '1) begin
              bad_run <= bad_run + 1'b1;
            end
          end else begin
            bad_run <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            window_closed  <= closed;
            measured_ratio <= last_ratio;
            bad_count      <= bad_run;
            skewed         <= bad_run >= bad_needed;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_skew_matches_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (skewed == (bad_count >= bad_needed)))
    else $error("skewed flag disagrees with bad count");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    ratio_done |-> (state == S_WAIT))
    else $error("ratio unit finished outside the wait state");

  a_run_clears_on_reset_of_window: assert property (@(posedge clk) disable iff (rst)
    $fell(seen_flag) |-> (bad_run == '0))
    else $error("bad run kept across a cleared monitor");

  a_start_only_on_close: assert property (@(posedge clk) disable iff (rst)
    ratio_start |=> (closed && state == S_WAIT))
    else $error("ratio started without closing a window");

endmodule
